>>> src/bati_pkg.sv
`default_nettype none
package bati_pkg;

  localparam int GRID_COLS = 32;
  localparam int GRID_ROWS = 16;
  localparam int COL_AW    = $clog2(GRID_COLS);
  localparam int ROW_AW    = $clog2(GRID_ROWS);
  localparam int PAD_W     = GRID_COLS + 2;
  localparam int PAD_AW    = $clog2(PAD_W);

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_QUERY  = 2'd0;
  localparam cmd_t CMD_PLACE  = 2'd1;
  localparam cmd_t CMD_REMOVE = 2'd2;

  typedef logic cfg_idx_t;
  localparam cfg_idx_t CFG_COLS = 1'b0;
  localparam cfg_idx_t CFG_ROWS = 1'b1;

  typedef logic [GRID_COLS-1:0] row_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD_C,
    S_RD_S,
    S_WR
  } state_t;

  typedef struct packed {
    logic [5:0] tile_code;
    logic [7:0] mask;
    logic       filled;
  } bati_res_t;

  // blob mask -> tile code; isolated tile (mask 0) is code 47
  function automatic logic [5:0] blob_code(input logic [7:0] mask);
    logic [5:0] code;
    case (mask)
      8'd0:   code = 6'd47;
      8'd2:   code = 6'd1;
      8'd8:   code = 6'd2;
      8'd10:  code = 6'd3;
      8'd11:  code = 6'd4;
      8'd16:  code = 6'd5;
      8'd18:  code = 6'd6;
      8'd22:  code = 6'd7;
      8'd24:  code = 6'd8;
      8'd26:  code = 6'd9;
      8'd27:  code = 6'd10;
      8'd30:  code = 6'd11;
      8'd31:  code = 6'd12;
      8'd64:  code = 6'd13;
      8'd66:  code = 6'd14;
      8'd72:  code = 6'd15;
      8'd74:  code = 6'd16;
      8'd75:  code = 6'd17;
      8'd80:  code = 6'd18;
      8'd82:  code = 6'd19;
      8'd86:  code = 6'd20;
      8'd88:  code = 6'd21;
      8'd90:  code = 6'd22;
      8'd91:  code = 6'd23;
      8'd94:  code = 6'd24;
      8'd95:  code = 6'd25;
      8'd104: code = 6'd26;
      8'd106: code = 6'd27;
      8'd107: code = 6'd28;
      8'd120: code = 6'd29;
      8'd122: code = 6'd30;
      8'd123: code = 6'd31;
      8'd126: code = 6'd32;
      8'd127: code = 6'd33;
      8'd208: code = 6'd34;
      8'd210: code = 6'd35;
      8'd214: code = 6'd36;
      8'd216: code = 6'd37;
      8'd218: code = 6'd38;
      8'd219: code = 6'd39;
      8'd222: code = 6'd40;
      8'd223: code = 6'd41;
      8'd248: code = 6'd42;
      8'd250: code = 6'd43;
      8'd251: code = 6'd44;
      8'd254: code = 6'd45;
      8'd255: code = 6'd46;
      default: code = 6'd0;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

>>> src/bati_ram.sv
`default_nettype none
module bati_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> src/bati_encode.sv
`default_nettype none
module bati_encode (
  input  wire bati_pkg::row_t                  row_n,
  input  wire bati_pkg::row_t                  row_c,
  input  wire bati_pkg::row_t                  row_s,
  input  wire logic [bati_pkg::COL_AW-1:0]     cell_x,
  output bati_pkg::bati_res_t                  res
);
  import bati_pkg::*;

  logic [PAD_W-1:0]  pad_n, pad_c, pad_s;
  logic [PAD_AW-1:0] pos;
  logic [2:0]        n3, c3, s3;
  logic              n, s, w, e, self_f;
  logic [7:0]        mask;

  // pad with an empty column on each side so x-1 and x+1 never fall off
  assign pad_n = {1'b0, row_n, 1'b0};
  assign pad_c = {1'b0, row_c, 1'b0};
  assign pad_s = {1'b0, row_s, 1'b0};
  assign pos   = PAD_AW'(cell_x);

  assign n3 = pad_n[pos +: 3];
  assign c3 = pad_c[pos +: 3];
  assign s3 = pad_s[pos +: 3];

  assign n      = n3[1];
  assign s      = s3[1];
  assign w      = c3[0];
  assign e      = c3[2];
  assign self_f = c3[1];

  always_comb begin
    mask    = '0;
    mask[0] = n & w & n3[0];
    mask[1] = n;
    mask[2] = n & e & n3[2];
    mask[3] = w;
    mask[4] = e;
    mask[5] = s & w & s3[0];
    mask[6] = s;
    mask[7] = s & e & s3[2];
  end

  assign res.mask      = mask;
  assign res.filled    = self_f;
  assign res.tile_code = self_f ? blob_code(mask) : 6'd0;

endmodule
`default_nettype wire

>>> src/blob_autotile_index.sv
`default_nettype none
// 47-tile blob autotiler over a 32x16 occupancy grid held as one row per RAM
// word. Each command (query, place, remove) returns the addressed cell's
// state, its 8-bit neighbour mask and blob tile code after the operation.
// For each item the single-read-port row RAM fetches the rows above,
// at and below the cell one per cycle, then the modified center row is written
// back while the result is loaded. A new item is taken only after the previous
// one's result is in the output register; that register holds a result while
// out_ready is low without blocking the next item's row reads. Per-row valid
// flops make the grid read as empty after reset, so no clearing pass is needed.
// Configuration writes (cfg_ready is always high) must happen while idle.
module blob_autotile_index (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  in_command,
  input  wire logic [4:0]                  in_cell_x,
  input  wire logic [3:0]                  in_cell_y,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [5:0]                  out_tile_code,
  output logic      [7:0]                  out_neighbour_mask,
  output logic                             out_cell_filled,
  output logic                             out_out_of_range,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire bati_pkg::cfg_idx_t          cfg_index,
  input  wire logic [5:0]                  cfg_data
);
  import bati_pkg::*;

  localparam logic [5:0] MAX_COLS = 6'(GRID_COLS);
  localparam logic [4:0] MAX_ROWS = 5'(GRID_ROWS);

  state_t state_r, state_nxt;

  logic [5:0] cols_r;
  logic [4:0] rows_r;
  logic [5:0] eff_cols;
  logic [4:0] eff_rows;
  row_t       col_mask;

  cmd_t              cmd_r;
  logic [COL_AW-1:0] x_r;
  logic [ROW_AW-1:0] y_r;
  logic              oor_r;
  logic              in_oor;

  logic [GRID_ROWS-1:0] row_vld_r;
  row_t                 north_r, ctr_raw_r;
  row_t                 ctr_new, row_c, row_s, ram_q;
  logic                 north_ok, south_ok;

  logic              ram_we;
  logic [ROW_AW-1:0] ram_raddr;
  logic              accept, load_out;

  bati_res_t res;

  logic       out_valid_r;
  logic [5:0] tile_r;
  logic [7:0] mask_r;
  logic       filled_r;
  logic       oor_out_r;

  // area in use, saturated to the grid
  assign eff_cols = (cols_r > MAX_COLS) ? MAX_COLS : cols_r;
  assign eff_rows = (rows_r > MAX_ROWS) ? MAX_ROWS : rows_r;

  always_comb begin
    for (int i = 0; i < GRID_COLS; i++) begin
      col_mask[i] = (6'(i) < eff_cols);
    end
  end

  assign in_oor = ({1'b0, in_cell_x} >= eff_cols) || ({1'b0, in_cell_y} >= eff_rows);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_RD_C;
      S_RD_C: state_nxt = S_RD_S;
      S_RD_S: state_nxt = S_WR;
      S_WR:   if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready  = 1'b0;
    load_out  = 1'b0;
    ram_raddr = y_r + ROW_AW'(1);
    unique case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        ram_raddr = in_cell_y - ROW_AW'(1);
      end
      S_RD_C: ram_raddr = y_r;
      S_RD_S: ram_raddr = y_r + ROW_AW'(1);
      S_WR: begin
        ram_raddr = y_r + ROW_AW'(1);
        load_out  = !out_valid_r || out_ready;
      end
      default: ram_raddr = y_r;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // latched item
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_command;
      x_r   <= in_cell_x;
      y_r   <= in_cell_y;
      oor_r <= in_oor;
    end
  end

  // north row needs y > 0; it is always inside the area when the cell is
  assign north_ok = (y_r != '0) && row_vld_r[y_r - ROW_AW'(1)];
  assign south_ok = (({1'b0, y_r} + 5'd1) < eff_rows) && row_vld_r[y_r + ROW_AW'(1)];

  always_ff @(posedge clk) begin
    if (state_r == S_RD_C) begin
      north_r <= north_ok ? (ram_q & col_mask) : '0;
    end
    if (state_r == S_RD_S) begin
      ctr_raw_r <= row_vld_r[y_r] ? ram_q : '0;
    end
  end

  always_comb begin
    ctr_new = ctr_raw_r;
    case (cmd_r)
      CMD_PLACE:  ctr_new[x_r] = 1'b1;
      CMD_REMOVE: ctr_new[x_r] = 1'b0;
      default:    ctr_new = ctr_raw_r;
    endcase
  end

  assign row_c  = ctr_new & col_mask;
  assign row_s  = south_ok ? (ram_q & col_mask) : '0;
  // rewriting the same word while the output stalls is harmless
  assign ram_we = (state_r == S_WR) && !oor_r &&
                  ((cmd_r == CMD_PLACE) || (cmd_r == CMD_REMOVE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (ram_we) begin
      row_vld_r[y_r] <= 1'b1;
    end
  end

  bati_ram #(
    .WIDTH (GRID_COLS),
    .DEPTH (GRID_ROWS)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (y_r),
    .wdata (ctr_new),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  bati_encode u_enc (
    .row_n  (north_r),
    .row_c  (row_c),
    .row_s  (row_s),
    .cell_x (x_r),
    .res    (res)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      tile_r    <= oor_r ? 6'd0 : res.tile_code;
      mask_r    <= oor_r ? 8'd0 : res.mask;
      filled_r  <= oor_r ? 1'b0 : res.filled;
      oor_out_r <= oor_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_tile_code      = tile_r;
  assign out_neighbour_mask = mask_r;
  assign out_cell_filled    = filled_r;
  assign out_out_of_range   = oor_out_r;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= 6'd25;
      rows_r <= 5'd14;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_COLS: cols_r <= cfg_data;
        CFG_ROWS: rows_r <= cfg_data[4:0];
        default:  cols_r <= cols_r;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bati_pkg::*;

  // command 3 has no name in the package; the block treats it as a query
  localparam cmd_t CMD_SPARE = 2'd3;

  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 8;

  typedef struct packed {
    cmd_t       cmd;
    logic [4:0] x;
    logic [3:0] y;
  } cell_op_t;

  typedef struct packed {
    logic [5:0] code;
    logic [7:0] mask;
    logic       filled;
    logic       oor;
  } tile_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic       in_valid = 1'b0;
  logic       in_ready;
  cmd_t       in_command = CMD_QUERY;
  logic [4:0] in_cell_x = '0;
  logic [3:0] in_cell_y = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [5:0] out_tile_code;
  logic [7:0] out_neighbour_mask;
  logic       out_cell_filled;
  logic       out_out_of_range;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  cfg_idx_t   cfg_index = CFG_COLS;
  logic [5:0] cfg_data = '0;

  blob_autotile_index dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_cell_x          (in_cell_x),
    .in_cell_y          (in_cell_y),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_tile_code      (out_tile_code),
    .out_neighbour_mask (out_neighbour_mask),
    .out_cell_filled    (out_cell_filled),
    .out_out_of_range   (out_out_of_range),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block: occupancy and area registers
  logic [GRID_COLS-1:0] occ_rows [GRID_ROWS];
  logic [5:0] reg_cols = 6'd25;
  logic [4:0] reg_rows = 5'd14;

  cell_op_t  pending_ops [$];
  tile_res_t expected_tiles [$];

  int fail_count = 0;
  int items_taken = 0;
  int results_seen = 0;
  int oor_count = 0;
  int settings_count = 1;
  logic [47:0] codes_seen = '0;

  // area as seen by the stimulus generator
  int area_c = 25;
  int area_r = 14;

  int hold_reqs = 0;
  int holds_served = 0;

  function automatic int eff_cols();
    return (reg_cols > GRID_COLS) ? GRID_COLS : int'(reg_cols);
  endfunction

  function automatic int eff_rows();
    return (reg_rows > GRID_ROWS) ? GRID_ROWS : int'(reg_rows);
  endfunction

  function automatic logic cell_at(int x, int y);
    if (x < 0 || y < 0 || x >= eff_cols() || y >= eff_rows())
      return 1'b0;
    return occ_rows[y][x];
  endfunction

  function automatic logic [5:0] tile_of(logic [7:0] m);
    logic [7:0] shapes [46];
    shapes = '{8'd2, 8'd8, 8'd10, 8'd11, 8'd16, 8'd18, 8'd22, 8'd24, 8'd26, 8'd27,
               8'd30, 8'd31, 8'd64, 8'd66, 8'd72, 8'd74, 8'd75, 8'd80, 8'd82, 8'd86,
               8'd88, 8'd90, 8'd91, 8'd94, 8'd95, 8'd104, 8'd106, 8'd107, 8'd120,
               8'd122, 8'd123, 8'd126, 8'd127, 8'd208, 8'd210, 8'd214, 8'd216,
               8'd218, 8'd219, 8'd222, 8'd223, 8'd248, 8'd250, 8'd251, 8'd254,
               8'd255};
    if (m == 8'd0)
      return 6'd47;
    for (int i = 0; i < 46; i++)
      if (shapes[i] == m)
        return 6'(i + 1);
    return 6'd0;
  endfunction

  function automatic tile_res_t predict_tile(cell_op_t op);
    tile_res_t r;
    int x, y;
    logic n, s, w, e;
    r = '0;
    if (int'(op.x) >= eff_cols() || int'(op.y) >= eff_rows()) begin
      r.oor = 1'b1;
      return r;
    end
    if (op.cmd == CMD_PLACE)
      occ_rows[op.y][op.x] = 1'b1;
    else if (op.cmd == CMD_REMOVE)
      occ_rows[op.y][op.x] = 1'b0;
    x = int'(op.x);
    y = int'(op.y);
    n = cell_at(x, y - 1);
    s = cell_at(x, y + 1);
    w = cell_at(x - 1, y);
    e = cell_at(x + 1, y);
    // diagonals only count with both adjacent edges filled
    r.mask[0] = n && w && cell_at(x - 1, y - 1);
    r.mask[1] = n;
    r.mask[2] = n && e && cell_at(x + 1, y - 1);
    r.mask[3] = w;
    r.mask[4] = e;
    r.mask[5] = s && w && cell_at(x - 1, y + 1);
    r.mask[6] = s;
    r.mask[7] = s && e && cell_at(x + 1, y + 1);
    r.filled = cell_at(x, y);
    r.code = r.filled ? tile_of(r.mask) : 6'd0;
    return r;
  endfunction

  // driver: bursts of words with random gaps
  always @(posedge clk) begin : drv
    cell_op_t nxt;
    int burst_left;
    int gap_left;
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 8;
      gap_left = 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_ops.size() != 0) begin
        nxt = pending_ops.pop_front();
        in_command <= nxt.cmd;
        in_cell_x <= nxt.x;
        in_cell_y <= nxt.y;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern changes every so often, plus requested long holds
  always @(posedge clk) begin : rcv
    int rcv_mode;
    int mode_left;
    int hold_left;
    int tick;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rcv_mode = 0;
      mode_left = 50;
      hold_left = 0;
      tick = 0;
    end else begin
      tick++;
      if (holds_served < hold_reqs) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        rcv_mode = $urandom_range(3);
        mode_left = $urandom_range(40, 160);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rcv_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(1));
          2: out_ready <= (tick % 4 == 0);
          default: out_ready <= ($urandom_range(3) != 0);
        endcase
      end
    end
  end

  // monitor: check results, predict accepted words, track registers, watchdog
  always @(posedge clk) begin : mon
    tile_res_t want;
    cell_op_t op;
    int quiet;
    if (!rst_n) begin
      quiet = 0;
    end else begin
      quiet++;
      if (out_valid && out_ready) begin
        quiet = 0;
        if (expected_tiles.size() == 0) begin
          $error("result with no pending expectation: code %0d mask %0d",
                 out_tile_code, out_neighbour_mask);
          fail_count++;
        end else begin
          want = expected_tiles.pop_front();
          results_seen++;
          if (out_tile_code !== want.code) begin
            $error("tile_code: expected %0d, got %0d", want.code, out_tile_code);
            fail_count++;
          end
          if (out_neighbour_mask !== want.mask) begin
            $error("neighbour_mask: expected %0d, got %0d", want.mask, out_neighbour_mask);
            fail_count++;
          end
          if (out_cell_filled !== want.filled) begin
            $error("cell_filled: expected %0d, got %0d", want.filled, out_cell_filled);
            fail_count++;
          end
          if (out_out_of_range !== want.oor) begin
            $error("out_of_range: expected %0d, got %0d", want.oor, out_out_of_range);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        quiet = 0;
        op.cmd = in_command;
        op.x = in_cell_x;
        op.y = in_cell_y;
        want = predict_tile(op);
        expected_tiles = {expected_tiles, want};
        items_taken++;
        if (want.oor)
          oor_count++;
        codes_seen[want.code] = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        quiet = 0;
        if (cfg_index == CFG_COLS)
          reg_cols = cfg_data;
        else
          reg_rows = cfg_data[4:0];
      end
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", quiet);
        $display("blob_autotile_index regression: fail");
        $finish;
      end
    end
  end

  task automatic push_op(cmd_t cmd, int x, int y);
    cell_op_t op;
    op.cmd = cmd;
    op.x = 5'(x);
    op.y = 4'(y);
    pending_ops = {pending_ops, op};
  endtask

  function automatic cell_op_t cluster_op(int hx, int hy);
    cell_op_t op;
    int pick, px, py;
    pick = $urandom_range(99);
    op.cmd = (pick < 45) ? CMD_PLACE : (pick < 70) ? CMD_REMOVE :
             (pick < 95) ? CMD_QUERY : CMD_SPARE;
    if ($urandom_range(9) == 0 || area_c == 0 || area_r == 0) begin
      op.x = 5'($urandom);
      op.y = 4'($urandom);
    end else begin
      px = hx - 2 + int'($urandom_range(4));
      py = hy - 2 + int'($urandom_range(4));
      if (px < 0) px = 0;
      if (px >= area_c) px = area_c - 1;
      if (py < 0) py = 0;
      if (py >= area_r) py = area_r - 1;
      op.x = 5'(px);
      op.y = 4'(py);
    end
    return op;
  endfunction

  // dense traffic around a hot spot that moves every 40 words
  task automatic push_random(int n);
    int hx, hy;
    hx = 0;
    hy = 0;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0 && area_c > 0 && area_r > 0) begin
        hx = $urandom_range(area_c - 1);
        hy = $urandom_range(area_r - 1);
      end
      pending_ops = {pending_ops, cluster_op(hx, hy)};
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_ops.size() != 0 || in_valid || expected_tiles.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [5:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_area(int c, int r);
    wait_idle();
    write_reg(CFG_COLS, 6'(c));
    write_reg(CFG_ROWS, 6'(r));
    area_c = (c > GRID_COLS) ? GRID_COLS : c;
    area_r = ((r % 32) > GRID_ROWS) ? GRID_ROWS : (r % 32);
    settings_count++;
  endtask

  initial begin
    for (int i = 0; i < GRID_ROWS; i++)
      occ_rows[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, reset area 25x14
    push_op(CMD_QUERY, 0, 0);
    push_op(CMD_PLACE, 0, 0);
    push_op(CMD_PLACE, 1, 0);
    push_op(CMD_PLACE, 0, 1);
    push_op(CMD_PLACE, 1, 1);
    push_op(CMD_QUERY, 0, 0);
    for (int yy = 5; yy <= 7; yy++)
      for (int xx = 5; xx <= 7; xx++)
        if (!(xx == 6 && yy == 6))
          push_op(CMD_PLACE, xx, yy);
    push_op(CMD_PLACE, 6, 6);     // fully surrounded
    push_op(CMD_REMOVE, 6, 6);    // empty cell, mask still reported
    push_op(CMD_REMOVE, 6, 6);
    push_op(CMD_PLACE, 0, 0);
    push_op(CMD_SPARE, 6, 5);
    push_op(CMD_PLACE, 25, 0);
    push_op(CMD_PLACE, 0, 14);
    push_op(CMD_QUERY, 31, 15);
    push_op(CMD_PLACE, 24, 13);
    push_op(CMD_QUERY, 24, 13);

    // full grid; fill the far corner so a later shrink hides most of it
    set_area(32, 16);
    for (int yy = 12; yy < 16; yy++)
      for (int xx = 26; xx < 32; xx++)
        if ($urandom_range(3) != 0)
          push_op(CMD_PLACE, xx, yy);
    push_random(150);
    @(negedge clk);
    hold_reqs++;

    set_area(27, 13);
    push_random(120);
    // oversize values saturate; hidden corner cells come back
    set_area(63, 31);
    push_random(120);
    set_area(0, 16);
    push_random(20);
    set_area(32, 0);
    push_random(20);
    set_area(1, 1);
    push_random(25);
    set_area(3, 6'h25);           // rows register keeps only five bits
    push_random(60);
    repeat (6) begin
      set_area($urandom_range(1, 40), $urandom_range(1, 20));
      push_random(60);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    $display("covered %0d words over %0d area settings, %0d out of range",
             items_taken, settings_count, oor_count);
    $display("%0d results checked, %0d of 48 tile codes produced",
             results_seen, $countones(codes_seen));
    if (fail_count == 0)
      $display("blob_autotile_index regression: pass");
    else
      $display("blob_autotile_index regression: fail");
    $finish;
  end

endmodule
